### hdl/hims_pkg.sv
// shared types, constants and codes for the hashed id membership set
// no dependencies; used by the block's modules but hims_ram, and its checker
package hims_pkg;

	// field widths
	localparam int ID_W        = 32;
	localparam int ACTION_W    = 2;
	localparam int STATUS_W    = 2;
	localparam int COUNT_W     = 13;
	localparam int HASH_BITS_W = 4;

	// default geometry
	localparam int INDEX_BITS_DEF = 10;
	localparam int WAYS_DEF       = 4;

	// multiplicative hash constant and register reset
	localparam logic [ID_W-1:0]        HASH_MULT       = 32'd2654435761;
	localparam logic [HASH_BITS_W-1:0] HASH_BITS_RESET = 4'd10;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_CHANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [ACTION_W-1:0]    action;
		logic signed [ID_W-1:0] id;
	} in_item_t;

	typedef struct packed {
		logic                found;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  entry_count;
	} out_item_t;

	// outcome of one bucket update
	typedef struct packed {
		logic                found;
		logic [STATUS_W-1:0] status;
		logic                row_we;
		logic                cnt_inc;
		logic                cnt_dec;
	} upd_t;

endpackage

### hdl/hashed_id_membership_set.sv
// top level of the hashed id membership set: control, bucket ram, count and sweep
// depends on hims_pkg, hims_ram, hims_hash, hims_update, hims_obuf
//
// Usage
// - in channel (in_valid/in_ready/in_item): one item asks find, add, remove or clear.
// - out channel (out_valid/out_ready/out_item): one result per item, in order.
// - cfg_we/cfg_wdata: writes the hash width; write only while the block is idle.
// - each bucket is one ram row holding WAYS valid bits and WAYS ids.
// - an item is handled as a bucket row read, then compare and write back;
//   the result is then registered in the output buffer. The single bucket
//   ram is read, then written, so a new item waits until the last is written back.
// - a clear item answers at once, then the ram is swept one row a cycle
//   over all 2**INDEX_BITS rows, with in_ready low.
// - after reset the same sweep of all 2**INDEX_BITS rows runs before the first
//   item is taken; configuration writes are taken during it.
// - results go through a two-entry buffer: while out_ready is low one more
//   item is accepted and processed, then in_ready drops until space frees.
module hashed_id_membership_set #(
	parameter int INDEX_BITS = hims_pkg::INDEX_BITS_DEF,
	parameter int WAYS       = hims_pkg::WAYS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  hims_pkg::in_item_t               in_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output hims_pkg::out_item_t              out_item,
	input  logic                             cfg_we,
	input  logic [hims_pkg::HASH_BITS_W-1:0] cfg_wdata
);

	localparam int IW    = hims_pkg::ID_W;
	localparam int CW    = hims_pkg::COUNT_W;
	localparam int ROW_W = WAYS * (IW + 1);
	localparam int DEPTH = 2 ** INDEX_BITS;

	localparam logic ST_RUN   = 1'b0;
	localparam logic ST_SWEEP = 1'b1;

	logic                             state_q;
	logic [INDEX_BITS-1:0]            sweep_addr_q;
	logic [hims_pkg::HASH_BITS_W-1:0] hash_bits_q;
	logic [CW-1:0]                    count_q;
	logic [CW-1:0]                    count_next;

	logic                          busy_s1;
	logic [hims_pkg::ACTION_W-1:0] action_s1;
	logic [IW-1:0]                 id_s1;
	logic [INDEX_BITS-1:0]         bucket_s1;

	logic                  in_fire;
	logic                  skid_full;
	logic [INDEX_BITS-1:0] bucket;
	logic                  is_clear_s1;

	logic                  ram_we;
	logic [INDEX_BITS-1:0] ram_waddr;
	logic [ROW_W-1:0]      ram_wdata;
	logic [ROW_W-1:0]      ram_rdata;

	logic [WAYS-1:0]    new_valid;
	logic [WAYS*IW-1:0] new_ids;
	hims_pkg::upd_t     upd;
	hims_pkg::out_item_t res;

	// one item in flight, none during the sweep or while the skid entry is full
	assign in_ready = (state_q == ST_RUN) && !busy_s1 && !skid_full;
	assign in_fire  = in_valid && in_ready;

	hims_hash #(
		.INDEX_BITS(INDEX_BITS)
	) u_hash (
		.id       (unsigned'(in_item.id)),
		.hash_bits(hash_bits_q),
		.bucket   (bucket)
	);

	hims_ram #(
		.WIDTH(ROW_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (in_fire),
		.raddr(bucket),
		.rdata(ram_rdata)
	);

	hims_update #(
		.WAYS(WAYS)
	) u_update (
		.action   (action_s1),
		.id       (id_s1),
		.row_valid(ram_rdata[ROW_W-1 -: WAYS]),
		.row_ids  (ram_rdata[WAYS*IW-1:0]),
		.new_valid(new_valid),
		.new_ids  (new_ids),
		.upd      (upd)
	);

	assign is_clear_s1 = (action_s1 == hims_pkg::ACT_CLEAR);

	// ram write: sweep zeroes rows, otherwise write back the bucket
	always_comb begin
		if (state_q == ST_SWEEP) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = busy_s1 && upd.row_we;
			ram_waddr = bucket_s1;
			ram_wdata = {new_valid, new_ids};
		end
	end

	// held count after this item
	always_comb begin
		if (is_clear_s1) begin
			count_next = '0;
		end else begin
			count_next = count_q + CW'(upd.cnt_inc) - CW'(upd.cnt_dec);
		end
	end

	assign res.found       = upd.found;
	assign res.status      = upd.status;
	assign res.entry_count = count_next;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			sweep_addr_q <= '0;
			hash_bits_q  <= hims_pkg::HASH_BITS_RESET;
			count_q      <= '0;
			busy_s1      <= 1'b0;
		end else begin
			if (cfg_we) begin
				hash_bits_q <= cfg_wdata;
			end
			busy_s1 <= in_fire;
			if (busy_s1) begin
				count_q <= count_next;
			end
			unique case (state_q)
				ST_RUN: begin
					if (busy_s1 && is_clear_s1) begin
						state_q      <= ST_SWEEP;
						sweep_addr_q <= '0;
					end
				end
				ST_SWEEP: begin
					if (sweep_addr_q == {INDEX_BITS{1'b1}}) begin
						state_q <= ST_RUN;
					end
					sweep_addr_q <= sweep_addr_q + INDEX_BITS'(1);
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	// item payload for the update cycle
	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_s1 <= in_item.action;
			id_s1     <= unsigned'(in_item.id);
			bucket_s1 <= bucket;
		end
	end

	hims_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_valid(busy_s1),
		.res      (res),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.skid_full(skid_full)
	);

endmodule

### hdl/hims_ram.sv
// generic single-clock ram, one write port and one read port, registered read
// no dependencies
module hims_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/hims_hash.sv
// bucket index: low bits of id times the multiplicative constant, masked to the hash width
// depends on hims_pkg
module hims_hash #(
	parameter int INDEX_BITS = hims_pkg::INDEX_BITS_DEF
) (
	input  logic [hims_pkg::ID_W-1:0]        id,
	input  logic [hims_pkg::HASH_BITS_W-1:0] hash_bits,
	output logic [INDEX_BITS-1:0]            bucket
);

	localparam int EW = $clog2(INDEX_BITS + 1) + 1;
	localparam logic [INDEX_BITS-1:0] MULT_LO = hims_pkg::HASH_MULT[INDEX_BITS-1:0];

	logic [INDEX_BITS-1:0] prod;
	logic [EW-1:0]         req_bits;
	logic [EW-1:0]         eff_bits;
	logic [INDEX_BITS-1:0] mask;

	// low product bits only depend on the low operand bits
	assign prod = id[INDEX_BITS-1:0] * MULT_LO;

	// out of range widths saturate to the full index
	always_comb begin
		req_bits = EW'(hash_bits);
		if (req_bits == '0 || req_bits > EW'(INDEX_BITS)) begin
			eff_bits = EW'(INDEX_BITS);
		end else begin
			eff_bits = req_bits;
		end
	end

	// keep the low eff_bits bits
	always_comb begin
		for (int i = 0; i < INDEX_BITS; i++) begin
			mask[i] = (EW'(i) < eff_bits);
		end
	end

	assign bucket = prod & mask;

endmodule

### hdl/hims_update.sv
// bucket row update: parallel way compare, free way pick, new valid bits and ids
// depends on hims_pkg
module hims_update #(
	parameter int WAYS = hims_pkg::WAYS_DEF
) (
	input  logic [hims_pkg::ACTION_W-1:0] action,
	input  logic [hims_pkg::ID_W-1:0]     id,
	input  logic [WAYS-1:0]               row_valid,
	input  logic [WAYS*hims_pkg::ID_W-1:0] row_ids,
	output logic [WAYS-1:0]               new_valid,
	output logic [WAYS*hims_pkg::ID_W-1:0] new_ids,
	output hims_pkg::upd_t                upd
);

	localparam int IW = hims_pkg::ID_W;

	logic [WAYS-1:0] match;
	logic [WAYS-1:0] match_lo;
	logic [WAYS-1:0] free;
	logic [WAYS-1:0] free_lo;
	logic            hit;
	logic            has_free;

	// compare every valid way against the id
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			match[w] = row_valid[w] && (row_ids[w*IW +: IW] == id);
		end
	end

	// lowest matching way and lowest free way
	assign match_lo = match & (~match + WAYS'(1));
	assign free     = ~row_valid;
	assign free_lo  = free & (~free + WAYS'(1));
	assign hit      = |match;
	assign has_free = |free;

	// new id goes into the lowest free way
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			new_ids[w*IW +: IW] = free_lo[w] ? id : row_ids[w*IW +: IW];
		end
	end

	// decide the outcome per action
	always_comb begin
		new_valid   = row_valid;
		upd.found   = hit;
		upd.status  = hims_pkg::ST_DONE;
		upd.row_we  = 1'b0;
		upd.cnt_inc = 1'b0;
		upd.cnt_dec = 1'b0;
		unique case (action)
			hims_pkg::ACT_FIND: begin
			end
			hims_pkg::ACT_ADD: begin
				if (hit) begin
					upd.status = hims_pkg::ST_NO_CHANGE;
				end else if (!has_free) begin
					upd.status = hims_pkg::ST_FULL;
				end else begin
					new_valid   = row_valid | free_lo;
					upd.row_we  = 1'b1;
					upd.cnt_inc = 1'b1;
				end
			end
			hims_pkg::ACT_REMOVE: begin
				if (hit) begin
					new_valid   = row_valid & ~match_lo;
					upd.row_we  = 1'b1;
					upd.cnt_dec = 1'b1;
				end else begin
					upd.status = hims_pkg::ST_NO_CHANGE;
				end
			end
			hims_pkg::ACT_CLEAR: begin
				upd.found = 1'b0;
			end
			default: begin
			end
		endcase
	end

endmodule

### hdl/hims_obuf.sv
// two-entry result buffer: output register plus skid entry
// depends on hims_pkg
module hims_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_valid,
	input  hims_pkg::out_item_t res,
	output logic                out_valid,
	input  logic                out_ready,
	output hims_pkg::out_item_t out_item,
	output logic                skid_full
);

	logic                out_valid_q;
	logic                skid_valid_q;
	hims_pkg::out_item_t out_q;
	hims_pkg::out_item_t skid_q;
	logic                out_open;

	assign out_open = !out_valid_q || out_ready;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_open) begin
			out_valid_q  <= skid_valid_q || res_valid;
			skid_valid_q <= skid_valid_q && res_valid;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload, oldest item first
	always_ff @(posedge clk) begin
		if (out_open) begin
			out_q  <= skid_valid_q ? skid_q : res;
			skid_q <= res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign skid_full = skid_valid_q;

endmodule

### hdl/hims_chk.sv
// port-level checker for the hashed id membership set, bound to the top level
// depends on hims_pkg and hashed_id_membership_set
module hims_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input hims_pkg::in_item_t  in_item,
	input logic                out_valid,
	input logic                out_ready,
	input hims_pkg::out_item_t out_item
);

	logic in_fire;
	assign in_fire = in_valid && in_ready;

	// one item at a time: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("item accepted while another is in flight");

	// a clear item is followed by the sweep
	a_clear_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_item.action == hims_pkg::ACT_CLEAR |=> ##1 !in_ready)
		else $error("item accepted during the clearing sweep");

	// a refused add never reports the id as present
	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == hims_pkg::ST_FULL |-> !out_item.found)
		else $error("bucket full result reports found");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

endmodule

bind hashed_id_membership_set hims_chk u_hims_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.in_item  (in_item),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_item (out_item)
);

### tb/testbench.sv
// self-checking testbench for hashed_id_membership_set: directed and random find/add/remove/clear
// depends on hims_pkg and the hashed_id_membership_set rtl; carries its own model of the set
`timescale 1ns / 1ps

module testbench;

	localparam int ID_W        = hims_pkg::ID_W;
	localparam int ACTION_W    = hims_pkg::ACTION_W;
	localparam int STATUS_W    = hims_pkg::STATUS_W;
	localparam int COUNT_W     = hims_pkg::COUNT_W;
	localparam int HASH_BITS_W = hims_pkg::HASH_BITS_W;
	localparam int NUM_BUCKETS = 1 << hims_pkg::INDEX_BITS_DEF;
	localparam int WAYS        = hims_pkg::WAYS_DEF;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 160;
	localparam int HOT_COUNT   = 6;
	localparam int RECENT_MAX  = 48;
	localparam int PROBE_COUNT = 22;
	localparam int DRAIN_CYCLES = 20;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	hims_pkg::in_item_t     in_item;
	logic                   out_valid;
	logic                   out_ready;
	hims_pkg::out_item_t    out_item;
	logic                   cfg_we;
	logic [HASH_BITS_W-1:0] cfg_wdata;

	hashed_id_membership_set i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// shadow copy of the set
	logic [ID_W-1:0]        shadow_ids [NUM_BUCKETS][WAYS];
	logic [WAYS-1:0]        shadow_valid [NUM_BUCKETS];
	logic [COUNT_W-1:0]     shadow_count;
	logic [HASH_BITS_W-1:0] shadow_hash_bits;

	hims_pkg::out_item_t awaited_results [$];
	logic [ID_W-1:0]     recent_ids [$];
	logic [9:0]          hot_low [HOT_COUNT];
	int                  mismatches;
	int                  send_idle_pct;
	int                  recv_stall_pct;

	// directed rows; typed rows carry their answer, the rest use the shadow set
	typedef struct {
		logic [ACTION_W-1:0] action;
		logic [ID_W-1:0]     id;
		bit                  typed;
		logic                found;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
	} probe_row_t;

	probe_row_t probe_rows [PROBE_COUNT] = '{
		'{hims_pkg::ACT_FIND,   32'h0000_0000, 1'b1, 1'b0, hims_pkg::ST_DONE,      13'd0},
		'{hims_pkg::ACT_REMOVE, 32'h7FFF_FFFF, 1'b1, 1'b0, hims_pkg::ST_NO_CHANGE, 13'd0},
		'{hims_pkg::ACT_ADD,    32'h8000_0000, 1'b1, 1'b0, hims_pkg::ST_DONE,      13'd1},
		'{hims_pkg::ACT_ADD,    32'h8000_0000, 1'b1, 1'b1, hims_pkg::ST_NO_CHANGE, 13'd1},
		'{hims_pkg::ACT_FIND,   32'h8000_0000, 1'b1, 1'b1, hims_pkg::ST_DONE,      13'd1},
		'{hims_pkg::ACT_ADD,    32'h7FFF_FFFF, 1'b0, 1'b0, hims_pkg::ST_DONE,      13'd0},
		'{hims_pkg::ACT_ADD,    32'hFFFF_FFFF, 1'b0, 1'b0, hims_pkg::ST_DONE,      13'd0},
		'{hims_pkg::ACT_ADD,    32'h0000_0400, 1'b0, 1'b0, hims_pkg::ST_DONE,      13'd0},
		'{hims_pkg::ACT_ADD,    32'h0000_0800, 1'b0, 1'b0, hims_pkg::ST_DONE,      13'd0},
		'{hims_pkg::ACT_ADD,    32'h0000_0C00, 1'b0, 1'b0, hims_pkg::ST_DONE,      13'd0},
		// bucket zero is full now
		'{hims_pkg::ACT_ADD,    32'h0000_1000, 1'b1, 1'b0, hims_pkg::ST_FULL,      13'd6},
		'{hims_pkg::ACT_REMOVE, 32'h0000_0400, 1'b1, 1'b1, hims_pkg::ST_DONE,      13'd5},
		'{hims_pkg::ACT_ADD,    32'h0000_1000, 1'b0, 1'b0, hims_pkg::ST_DONE,      13'd0},
		'{hims_pkg::ACT_FIND,   32'h0000_0400, 1'b0, 1'b0, hims_pkg::ST_DONE,      13'd0},
		'{hims_pkg::ACT_REMOVE, 32'h0000_0400, 1'b1, 1'b0, hims_pkg::ST_NO_CHANGE, 13'd6},
		'{hims_pkg::ACT_ADD,    32'h0000_0000, 1'b1, 1'b0, hims_pkg::ST_FULL,      13'd6},
		'{hims_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 1'b0, 1'b0, hims_pkg::ST_DONE,      13'd0},
		'{hims_pkg::ACT_FIND,   32'h7FFF_FFFF, 1'b0, 1'b0, hims_pkg::ST_DONE,      13'd0},
		'{hims_pkg::ACT_CLEAR,  32'h5A5A_5A5A, 1'b1, 1'b0, hims_pkg::ST_DONE,      13'd0},
		'{hims_pkg::ACT_FIND,   32'h8000_0000, 1'b1, 1'b0, hims_pkg::ST_DONE,      13'd0},
		'{hims_pkg::ACT_ADD,    32'h5555_5555, 1'b0, 1'b0, hims_pkg::ST_DONE,      13'd0},
		'{hims_pkg::ACT_REMOVE, 32'hAAAA_AAAA, 1'b0, 1'b0, hims_pkg::ST_DONE,      13'd0}
	};

	// hash width per phase, out of range values among them
	logic [HASH_BITS_W-1:0] phase_hash_bits [PHASES] = '{
		4'd10, 4'd1, 4'd0, 4'd4, 4'd15, 4'd2, 4'd10, 4'd11, 4'd3, 4'd7, 4'd1, 4'd6
	};

	// bucket of an id under the current hash width
	function automatic int unsigned bucket_of_id(logic [ID_W-1:0] id);
		logic [ID_W-1:0] h;
		int unsigned     width;
		width = shadow_hash_bits;
		if (width == 0 || width > hims_pkg::INDEX_BITS_DEF)
			width = hims_pkg::INDEX_BITS_DEF;
		h = id * hims_pkg::HASH_MULT;
		return h & ((32'd1 << width) - 1);
	endfunction

	// apply one request to the shadow set and return the answer it gives
	function automatic hims_pkg::out_item_t apply_to_shadow(hims_pkg::in_item_t req);
		hims_pkg::out_item_t res;
		int unsigned         bkt;
		int                  hit_way;
		int                  free_way;
		res.found       = 1'b0;
		res.status      = hims_pkg::ST_DONE;
		hit_way         = -1;
		free_way        = -1;
		if (req.action == hims_pkg::ACT_CLEAR) begin
			for (int b = 0; b < NUM_BUCKETS; b++)
				shadow_valid[b] = '0;
			shadow_count = '0;
		end else begin
			bkt = bucket_of_id(req.id);
			for (int w = 0; w < WAYS; w++) begin
				if (hit_way < 0 && shadow_valid[bkt][w] && shadow_ids[bkt][w] == req.id)
					hit_way = w;
				if (free_way < 0 && !shadow_valid[bkt][w])
					free_way = w;
			end
			res.found = (hit_way >= 0);
			if (req.action == hims_pkg::ACT_ADD) begin
				if (res.found) begin
					res.status = hims_pkg::ST_NO_CHANGE;
				end else if (free_way < 0) begin
					res.status = hims_pkg::ST_FULL;
				end else begin
					shadow_ids[bkt][free_way]   = req.id;
					shadow_valid[bkt][free_way] = 1'b1;
					shadow_count                = shadow_count + 1'b1;
				end
			end else if (req.action == hims_pkg::ACT_REMOVE) begin
				if (res.found) begin
					shadow_valid[bkt][hit_way] = 1'b0;
					shadow_count               = shadow_count - 1'b1;
				end else begin
					res.status = hims_pkg::ST_NO_CHANGE;
				end
			end
		end
		res.entry_count = shadow_count;
		return res;
	endfunction

	// mostly ids that collide or repeat, with some fully random noise
	function automatic hims_pkg::in_item_t random_request();
		hims_pkg::in_item_t req;
		int unsigned        pick;
		int unsigned        op;
		pick = $urandom_range(0, 99);
		op   = $urandom_range(0, 99);
		if (pick < 45 && recent_ids.size() > 0)
			req.id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
		else if (pick < 85)
			req.id = {22'($urandom()), hot_low[$urandom_range(0, HOT_COUNT - 1)]};
		else
			req.id = $urandom();
		if (op < 2)
			req.action = hims_pkg::ACT_CLEAR;
		else if (op < 40)
			req.action = hims_pkg::ACT_ADD;
		else if (op < 70)
			req.action = hims_pkg::ACT_REMOVE;
		else
			req.action = hims_pkg::ACT_FIND;
		if (req.action == hims_pkg::ACT_ADD) begin
			recent_ids.push_back(req.id);
			if (recent_ids.size() > RECENT_MAX)
				void'(recent_ids.pop_front());
		end
		return req;
	endfunction

	// offer one item, with random idle cycles first, and return once it is taken
	task automatic send_request(hims_pkg::in_item_t req);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= req;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// hash width write, only once every answer is back and the block takes items
	task automatic write_hash_bits(logic [HASH_BITS_W-1:0] value);
		while (awaited_results.size() != 0 || !in_ready)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we           <= 1'b0;
		shadow_hash_bits  = value;
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result side: random stalls and in-order compare
	always @(posedge clk) begin
		hims_pkg::out_item_t want;
		if (out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				$error("unexpected result: found %0d status %0d entry_count %0d",
					out_item.found, out_item.status, out_item.entry_count);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				if (out_item.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, out_item.found);
					mismatches++;
				end
				if (out_item.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, out_item.status);
					mismatches++;
				end
				if (out_item.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d",
						want.entry_count, out_item.entry_count);
					mismatches++;
				end
			end
		end
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// stimulus and end of run
	initial begin
		hims_pkg::in_item_t  req;
		hims_pkg::out_item_t got;
		hims_pkg::out_item_t typed_answer;
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		in_item        <= '0;
		out_ready      <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_wdata      <= '0;
		mismatches      = 0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		shadow_count     = '0;
		shadow_hash_bits = hims_pkg::HASH_BITS_RESET;
		for (int b = 0; b < NUM_BUCKETS; b++) begin
			shadow_valid[b] = '0;
			for (int w = 0; w < WAYS; w++)
				shadow_ids[b][w] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at the reset hash width
		for (int r = 0; r < PROBE_COUNT; r++) begin
			req.action = probe_rows[r].action;
			req.id     = probe_rows[r].id;
			send_request(req);
			got = apply_to_shadow(req);
			if (probe_rows[r].typed) begin
				typed_answer.found       = probe_rows[r].found;
				typed_answer.status      = probe_rows[r].status;
				typed_answer.entry_count = probe_rows[r].count;
				awaited_results.push_back(typed_answer);
			end else begin
				awaited_results.push_back(got);
			end
		end
		in_valid <= 1'b0;

		// random phases: new hash width and idle and stall pattern each, no clear between phases
		for (int p = 0; p < PHASES; p++) begin
			write_hash_bits(phase_hash_bits[p]);
			case (p % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 55;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 55;
				end
				default: begin
					send_idle_pct  = 24;
					recv_stall_pct = 24;
				end
			endcase
			for (int h = 0; h < HOT_COUNT; h++)
				hot_low[h] = 10'($urandom());
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				req = random_request();
				send_request(req);
				awaited_results.push_back(apply_to_shadow(req));
			end
			in_valid <= 1'b0;
		end

		// drain, then watch a little longer for stray results
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("hashed_id_membership_set regression: pass");
		end else begin
			$display("hashed_id_membership_set regression: fail");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run including clear sweeps
	initial begin
		#8_000_000;
		$display("hashed_id_membership_set regression: fail");
		$finish;
	end

endmodule

### hashed_id_membership_set.f
hdl/hims_pkg.sv
hdl/hims_ram.sv
hdl/hims_hash.sv
hdl/hims_update.sv
hdl/hims_obuf.sv
hdl/hashed_id_membership_set.sv
hdl/hims_chk.sv
tb/testbench.sv
